@@ hw/rtl/xmodem_block_sender_top_assert.svh @@
// assertion macros shared by the xmodem block sender rtl
// expects signals clk and rst_n in the module that uses them
`ifndef XMODEM_BLOCK_SENDER_TOP_ASSERT_SVH
`define XMODEM_BLOCK_SENDER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define XBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define XBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/xbs_pkg.sv @@
// shared types, constants and protocol codes of the xmodem block sender
// no dependencies
`default_nettype none

package xbs_pkg;

  localparam int DATA_BYTES = 5;
  localparam int IDX_W      = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam int CNT_W      = $clog2(DATA_BYTES + 1);
  localparam int CMD_DEPTH  = 2;
  localparam int CPTR_W     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CCNT_W     = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] C_SOH = 8'h01;
  localparam logic [7:0] C_PAD = 8'h03;
  localparam logic [7:0] C_EOT = 8'h04;
  localparam logic [7:0] C_ACK = 8'h06;
  localparam logic [7:0] C_NAK = 8'h15;
  localparam logic [7:0] C_CAN = 8'h18;

  typedef enum logic [1:0] {
    OP_RX      = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_END     = 2'd2,
    OP_BAD     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_FILL  = 3'd1,
    PH_BLOCK = 3'd2,
    PH_EOT   = 3'd3,
    PH_DONE  = 3'd4,
    PH_ABORT = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_NUM,
    BS_NNUM,
    BS_DATA,
    BS_SUM
  } bs_state_t;

  typedef enum logic {
    CK_SINGLE,
    CK_BLOCK
  } cmd_kind_t;

  // one request for the back end
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       rejected;
    phase_t     phase;
    logic [7:0] blk_num;
  } cmd_t;

  // buffer write from the front end
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  // framing info of the current block
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [7:0]       pad;
  } blk_info_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/xbs_cmd_fifo.sv @@
// short request queue between front end and back end
// depends on xbs_pkg
`default_nettype none

module xbs_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire xbs_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output xbs_pkg::cmd_t      head,
  output logic               full,
  output logic               empty
);
  import xbs_pkg::*;

  cmd_t              mem_r [CMD_DEPTH];
  logic [CPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CCNT_W'(CMD_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == CPTR_W'(CMD_DEPTH - 1)) ? '0 : CPTR_W'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == CPTR_W'(CMD_DEPTH - 1)) ? '0 : CPTR_W'(rp_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/xbs_front.sv @@
// front end: accepts items, runs the transfer phases, queues requests
// depends on xbs_pkg
`default_nettype none

module xbs_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [1:0]          in_op,
  input  wire logic [7:0]          in_byte,
  input  wire logic                q_full,
  input  wire logic                q_empty,
  input  wire xbs_pkg::back_stat_t back_stat,
  output logic                     q_push,
  output xbs_pkg::cmd_t            q_cmd,
  output xbs_pkg::buf_wr_t         buf_wr,
  output xbs_pkg::blk_info_t       blk_info
);
  import xbs_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       blknum_r, blknum_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             final_r, final_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [7:0]       bpad_r, bpad_nxt;
  logic [7:0]       cfg_pad_r;
  logic             fire;
  op_t              op;

  // buffer is shared with the back end: hold off filling while a block is out
  assign in_tready = !q_full &&
                     !((phase_r == PH_FILL) && (!q_empty || back_stat.busy));
  assign fire      = in_tvalid && in_tready;
  assign op        = op_t'(in_op);
  assign q_push    = fire;
  assign blk_info  = '{len: len_r, pad: bpad_r};

  always_comb begin
    phase_nxt  = phase_r;
    blknum_nxt = blknum_r;
    fill_nxt   = fill_r;
    final_nxt  = final_r;
    len_nxt    = len_r;
    bpad_nxt   = bpad_r;
    q_cmd      = '{kind: CK_SINGLE, tx_byte: 8'd0, tx_valid: 1'b0, rejected: 1'b0,
                   phase: phase_r, blk_num: blknum_r};
    buf_wr     = '{en: 1'b0, addr: fill_r[IDX_W-1:0], data: in_byte};
    if (fire) begin
      if (op == OP_RX && phase_r == PH_WAIT) begin
        phase_nxt = (in_byte == C_NAK) ? PH_FILL : PH_ABORT;
      end else if (op == OP_PAYLOAD && phase_r == PH_FILL) begin
        buf_wr.en = 1'b1;
        fill_nxt  = CNT_W'(fill_r + 1'b1);
        if (fill_nxt == CNT_W'(DATA_BYTES)) begin
          phase_nxt  = PH_BLOCK;
          len_nxt    = CNT_W'(DATA_BYTES);
          q_cmd.kind = CK_BLOCK;
        end
      end else if (op == OP_END && phase_r == PH_FILL) begin
        if (fill_r == '0) begin
          phase_nxt      = PH_EOT;
          q_cmd.tx_byte  = C_EOT;
          q_cmd.tx_valid = 1'b1;
        end else begin
          len_nxt    = fill_r;
          bpad_nxt   = cfg_pad_r;
          final_nxt  = 1'b1;
          phase_nxt  = PH_BLOCK;
          q_cmd.kind = CK_BLOCK;
        end
      end else if (op == OP_RX && phase_r == PH_BLOCK) begin
        if (in_byte == C_ACK) begin
          blknum_nxt = 8'(blknum_r + 1'b1);
          fill_nxt   = '0;
          if (final_r) begin
            final_nxt      = 1'b0;
            phase_nxt      = PH_EOT;
            q_cmd.tx_byte  = C_EOT;
            q_cmd.tx_valid = 1'b1;
          end else begin
            phase_nxt = PH_FILL;
          end
        end else if (in_byte == C_NAK) begin
          q_cmd.kind = CK_BLOCK;
        end else begin
          phase_nxt      = PH_ABORT;
          q_cmd.tx_byte  = C_CAN;
          q_cmd.tx_valid = 1'b1;
        end
      end else if (op == OP_RX && phase_r == PH_EOT) begin
        phase_nxt = PH_DONE;
      end else begin
        q_cmd.rejected = 1'b1;
      end
      q_cmd.phase = phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      blknum_r  <= 8'd1;
      fill_r    <= '0;
      final_r   <= 1'b0;
      cfg_pad_r <= C_PAD;
    end else begin
      phase_r  <= phase_nxt;
      blknum_r <= blknum_nxt;
      fill_r   <= fill_nxt;
      final_r  <= final_nxt;
      if (cfg_wr_en) begin
        cfg_pad_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    bpad_r <= bpad_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/xbs_back.sv @@
// back end: holds the block buffer and walks requests out as result bytes
// depends on xbs_pkg and xmodem_block_sender_top_assert.svh
`default_nettype none
`include "xmodem_block_sender_top_assert.svh"

module xbs_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire xbs_pkg::buf_wr_t   buf_wr,
  input  wire xbs_pkg::blk_info_t blk_info,
  input  wire logic               q_empty,
  input  wire xbs_pkg::cmd_t      q_head,
  output logic                    q_pop,
  output xbs_pkg::back_stat_t     back_stat,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tx_byte,
  output logic                    out_tx_valid,
  output logic                    out_last,
  output logic [2:0]              out_phase,
  output logic                    out_rejected
);
  import xbs_pkg::*;

  logic [7:0]       buf_mem [DATA_BYTES];
  logic [7:0]       rd_data_r;
  bs_state_t        state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       bnum_r, bnum_nxt;
  phase_t           bph_r, bph_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             otv_r, otv_nxt;
  logic             olast_r, olast_nxt;
  phase_t           oph_r, oph_nxt;
  logic             orej_r, orej_nxt;
  logic             adv;
  logic [7:0]       data_byte;

  assign adv            = !ov_r || out_tready;
  assign back_stat.busy = (state_r != BS_IDLE);
  assign data_byte      = (CNT_W'(idx_r) < blk_info.len) ? rd_data_r : blk_info.pad;

  assign out_tvalid   = ov_r;
  assign out_tx_byte  = ob_r;
  assign out_tx_valid = otv_r;
  assign out_last     = olast_r;
  assign out_phase    = oph_r;
  assign out_rejected = orej_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    bnum_nxt  = bnum_r;
    bph_nxt   = bph_r;
    ov_nxt    = ov_r && !out_tready;
    ob_nxt    = ob_r;
    otv_nxt   = otv_r;
    olast_nxt = olast_r;
    oph_nxt   = oph_r;
    orej_nxt  = orej_r;
    q_pop     = 1'b0;
    if (adv) begin
      case (state_r)
        BS_IDLE: begin
          if (!q_empty) begin
            q_pop  = 1'b1;
            ov_nxt = 1'b1;
            oph_nxt = q_head.phase;
            if (q_head.kind == CK_BLOCK) begin
              ob_nxt    = C_SOH;
              otv_nxt   = 1'b1;
              olast_nxt = 1'b0;
              orej_nxt  = 1'b0;
              bnum_nxt  = q_head.blk_num;
              bph_nxt   = q_head.phase;
              state_nxt = BS_NUM;
            end else begin
              ob_nxt    = q_head.tx_byte;
              otv_nxt   = q_head.tx_valid;
              olast_nxt = 1'b1;
              orej_nxt  = q_head.rejected;
            end
          end
        end
        BS_NUM: begin
          ov_nxt    = 1'b1;
          ob_nxt    = bnum_r;
          state_nxt = BS_NNUM;
        end
        BS_NNUM: begin
          ov_nxt    = 1'b1;
          ob_nxt    = ~bnum_r;
          idx_nxt   = '0;
          sum_nxt   = 8'd0;
          state_nxt = BS_DATA;
        end
        BS_DATA: begin
          ov_nxt  = 1'b1;
          ob_nxt  = data_byte;
          sum_nxt = 8'(sum_r + data_byte);
          if (idx_r == IDX_W'(DATA_BYTES - 1)) begin
            state_nxt = BS_SUM;
          end else begin
            idx_nxt = IDX_W'(idx_r + 1'b1);
          end
        end
        BS_SUM: begin
          ov_nxt    = 1'b1;
          ob_nxt    = sum_r;
          olast_nxt = 1'b1;
          state_nxt = BS_IDLE;
        end
        default: begin
          state_nxt = BS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    sum_r   <= sum_nxt;
    bnum_r  <= bnum_nxt;
    bph_r   <= bph_nxt;
    ob_r    <= ob_nxt;
    otv_r   <= otv_nxt;
    olast_r <= olast_nxt;
    oph_r   <= oph_nxt;
    orej_r  <= orej_nxt;
  end

  // block buffer, registered read one entry ahead of the walk
  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      buf_mem[buf_wr.addr] <= buf_wr.data;
    end
    rd_data_r <= buf_mem[idx_nxt];
  end

  `XBS_ASSERT_NOW(a_no_fill_while_busy, state_r != BS_IDLE, !buf_wr.en, "buffer written during block")
  `XBS_ASSERT_NOW(a_mid_block_result, ov_r && !olast_r, state_r != BS_IDLE, "non-final result outside block")
  `XBS_ASSERT_NEXT(a_sum_ends_block, state_r == BS_SUM && adv, state_r == BS_IDLE && olast_r, "block not closed after checksum")
  `XBS_ASSERT_NOW(a_block_phase, state_r != BS_IDLE, bph_r == PH_BLOCK, "block walked outside ack phase")

endmodule

`default_nettype wire

@@ hw/rtl/xmodem_block_sender_top.sv @@
// top level of the xmodem block sender: front end, request queue, back end
// depends on xbs_pkg, xbs_front, xbs_cmd_fifo, xbs_back
`default_nettype none
// an accepted request reaches the result channel through the queue and then the output register
// throughput: one request per cycle while the queue is not full, but in the filling phase a
//   request waits for an empty queue and an idle back end (shared block buffer)
// a block request gives DATA_BYTES + 4 results, walked one per cycle while out_tready is high
// reset: synchronous active-low rst_n; phase to wait-start, block number 1, pad byte 3,
//   queue and output emptied; block buffer contents are not cleared

module xmodem_block_sender_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: pad byte
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] tx_byte, [8] tx_valid, [11:9] phase,
                                       // [12] rejected, [15:13] zero
  output logic             out_tlast   // last result of a request
);
  import xbs_pkg::*;

  logic       q_push, q_pop, q_full, q_empty;
  cmd_t       q_cmd, q_head;
  buf_wr_t    buf_wr;
  blk_info_t  blk_info;
  back_stat_t back_stat;
  logic [7:0] o_byte;
  logic       o_txv, o_rej;
  logic [2:0] o_phase;

  // classifies requests and keeps the transfer phase
  xbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .in_byte    (in_tdata),
    .q_full     (q_full),
    .q_empty    (q_empty),
    .back_stat  (back_stat),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .buf_wr     (buf_wr),
    .blk_info   (blk_info)
  );

  // decouples the two sides
  xbs_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // frames blocks and drives the result register
  xbs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .buf_wr      (buf_wr),
    .blk_info    (blk_info),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .back_stat   (back_stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tx_byte (o_byte),
    .out_tx_valid(o_txv),
    .out_last    (out_tlast),
    .out_phase   (o_phase),
    .out_rejected(o_rej)
  );

  assign out_tdata = {3'b000, o_rej, o_phase, o_txv, o_byte};

endmodule

`default_nettype wire

@@ dv/xmodem_block_sender_top_test.sv @@
// self-checking testbench of the xmodem block sender: directed table, then random blocks and a random end
// depends on xbs_pkg and xmodem_block_sender_top; each result is checked against a predictor or a typed row
`timescale 1ns / 1ps

module xmodem_block_sender_top_test;
  import xbs_pkg::*;

  localparam int RAND_BLOCKS = 50;   // about 380 requests in all
  localparam int HOLD_AT     = 40;   // block at which the receiver holds off
  localparam int HOLD_CYCLES = 400;
  localparam int PAD_ZERO_AT = 25;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 24;
  localparam int NUM_ROWS    = 22;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;
  typedef enum int {FIN_PADDED, FIN_EMPTY, FIN_CANCEL} fin_kind_t;

  // one transmitted byte slot as the result channel reports it
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    phase_t     phase;
    logic       rejected;
  } tx_word_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] d;
    logic       typed;
    tx_word_t   want;
  } dir_row_t;

  localparam tx_word_t NO_WORD = '0;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  // typed expectation travels with the request it belongs to
  logic        drv_typed;
  tx_word_t    drv_word;

  gap_mode_t   gap_mode;
  bit          hold_req;
  int          hold_cnt;
  int          mismatches;
  int          stall_run;

  // predictor state
  phase_t      m_phase;
  logic [7:0]  m_blk;
  logic [7:0]  m_buf [DATA_BYTES];
  int          m_fill;
  logic        m_final;
  logic [7:0]  m_pad;
  tx_word_t    step_q [$];
  tx_word_t    tx_words_due [$];

  xmodem_block_sender_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic tx_word_t rej(phase_t p);
    return '{8'h00, 1'b0, 1'b1, p, 1'b1};
  endfunction

  function automatic tx_word_t quiet(phase_t p);
    return '{8'h00, 1'b0, 1'b1, p, 1'b0};
  endfunction

  function automatic int send_gap_pct();
    return (gap_mode == GAP_SEND) ? 62 : (gap_mode == GAP_BOTH) ? 12 : 0;
  endfunction

  function automatic int recv_gap_pct();
    return (gap_mode == GAP_RECV) ? 62 : (gap_mode == GAP_BOTH) ? 12 : 0;
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic void emit(logic [7:0] b, logic v, logic r);
    step_q.push_back('{v ? b : 8'h00, v, 1'b0, PH_WAIT, r});
  endfunction

  // SOH, number, complement, data, additive checksum
  function automatic void frame_block();
    logic [7:0] sum;
    sum = 8'h00;
    emit(C_SOH, 1'b1, 1'b0);
    emit(m_blk, 1'b1, 1'b0);
    emit(8'hFF - m_blk, 1'b1, 1'b0);
    for (int i = 0; i < DATA_BYTES; i++) begin
      emit(m_buf[i], 1'b1, 1'b0);
      sum += m_buf[i];
    end
    emit(sum, 1'b1, 1'b0);
  endfunction

  function automatic void predict_tx(op_t op, logic [7:0] d, logic typed, tx_word_t want);
    tx_word_t w;
    step_q.delete();
    if (op == OP_RX && m_phase == PH_WAIT) begin
      m_phase = (d == C_NAK) ? PH_FILL : PH_ABORT;
      emit(8'h00, 1'b0, 1'b0);
    end else if (op == OP_PAYLOAD && m_phase == PH_FILL) begin
      m_buf[m_fill] = d;
      m_fill++;
      if (m_fill == DATA_BYTES) begin
        m_phase = PH_BLOCK;
        frame_block();
      end else begin
        emit(8'h00, 1'b0, 1'b0);
      end
    end else if (op == OP_END && m_phase == PH_FILL) begin
      if (m_fill == 0) begin
        // nothing buffered: straight to end of transmission
        m_phase = PH_EOT;
        emit(C_EOT, 1'b1, 1'b0);
      end else begin
        for (int i = m_fill; i < DATA_BYTES; i++) m_buf[i] = m_pad;
        m_fill  = DATA_BYTES;
        m_final = 1'b1;
        m_phase = PH_BLOCK;
        frame_block();
      end
    end else if (op == OP_RX && m_phase == PH_BLOCK) begin
      if (d == C_ACK) begin
        m_blk  = m_blk + 8'd1;
        m_fill = 0;
        if (m_final) begin
          m_final = 1'b0;
          m_phase = PH_EOT;
          emit(C_EOT, 1'b1, 1'b0);
        end else begin
          m_phase = PH_FILL;
          emit(8'h00, 1'b0, 1'b0);
        end
      end else if (d == C_NAK) begin
        frame_block();
      end else begin
        m_phase = PH_ABORT;
        emit(C_CAN, 1'b1, 1'b0);
      end
    end else if (op == OP_RX && m_phase == PH_EOT) begin
      m_phase = PH_DONE;
      emit(8'h00, 1'b0, 1'b0);
    end else begin
      emit(8'h00, 1'b0, 1'b1);
    end

    if (typed) begin
      tx_words_due.push_back(want);
    end else begin
      foreach (step_q[i]) begin
        w       = step_q[i];
        w.phase = m_phase;
        w.last  = (i == step_q.size() - 1);
        tx_words_due.push_back(w);
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // requests feed the predictor, results are popped in order; also the watchdog
  always @(posedge clk) begin
    tx_word_t got;
    tx_word_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict_tx(op_t'(in_tuser), in_tdata, drv_typed, drv_word);
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[7:0], out_tdata[8], out_tlast, phase_t'(out_tdata[11:9]),
                out_tdata[12]};
        if (tx_words_due.size() == 0) begin
          $display("%0t: result expected none got %0h", $time, got);
          mismatches++;
        end else begin
          want = tx_words_due.pop_front();
          flag_field("tx_byte", want.tx_byte, got.tx_byte);
          flag_field("tx_valid", want.tx_valid, got.tx_valid);
          flag_field("last", want.last, got.last);
          flag_field("phase", want.phase, got.phase);
          flag_field("rejected", want.rejected, got.rejected);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_run = 0;
      end else begin
        stall_run++;
        if (stall_run >= STALL_LIMIT) begin
          $display("xmodem_block_sender_top_test: done, errors");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stalls per gap mode; a hold request blocks the output for a long stretch
  initial begin
    out_tready = 1'b0;
    hold_cnt   = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_gap_pct());
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // offer one request and return at the edge where it is taken
  task automatic offer(op_t op, logic [7:0] d, logic typed = 1'b0, tx_word_t want = NO_WORD);
    while ($urandom_range(0, 99) < send_gap_pct()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    drv_typed <= typed;
    drv_word  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  // a request the current phase must refuse
  task automatic noise_item(phase_t where);
    op_t op;
    case (where)
      PH_FILL:           op = $urandom_range(0, 1) ? OP_RX : OP_BAD;
      PH_DONE, PH_ABORT: op = op_t'($urandom_range(0, 3));
      default:           op = op_t'($urandom_range(1, 3));
    endcase
    offer(op, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_payload(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) noise_item(PH_FILL);
      offer(OP_PAYLOAD, 8'($urandom_range(0, 255)));
    end
  endtask

  // pad byte changes only once every result is out
  task automatic set_pad(logic [7:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tx_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    m_pad = v;
  endtask

  initial begin
    dir_row_t   dir_rows [NUM_ROWS];
    fin_kind_t  fin;
    logic [7:0] bad;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'h00;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = 2'd0;
    drv_typed   = 1'b0;
    drv_word    = NO_WORD;
    gap_mode    = GAP_NONE;
    hold_req    = 1'b0;
    mismatches  = 0;
    stall_run   = 0;

    m_phase = PH_WAIT;
    m_blk   = 8'd1;
    m_fill  = 0;
    m_final = 1'b0;
    m_pad   = C_PAD;
    foreach (m_buf[i]) m_buf[i] = 8'h00;

    // wrong-phase requests, start NAK, one block with resend, a second block
    dir_rows[0]  = '{OP_BAD,     8'hFF, 1'b1, rej(PH_WAIT)};
    dir_rows[1]  = '{OP_PAYLOAD, 8'h00, 1'b1, rej(PH_WAIT)};
    dir_rows[2]  = '{OP_END,     8'hAA, 1'b1, rej(PH_WAIT)};
    dir_rows[3]  = '{OP_RX,      C_NAK, 1'b1, quiet(PH_FILL)};
    dir_rows[4]  = '{OP_RX,      8'hFF, 1'b1, rej(PH_FILL)};
    dir_rows[5]  = '{OP_BAD,     8'h00, 1'b1, rej(PH_FILL)};
    dir_rows[6]  = '{OP_PAYLOAD, 8'h00, 1'b1, quiet(PH_FILL)};
    dir_rows[7]  = '{OP_PAYLOAD, 8'hFF, 1'b0, NO_WORD};
    dir_rows[8]  = '{OP_PAYLOAD, 8'h80, 1'b0, NO_WORD};
    dir_rows[9]  = '{OP_PAYLOAD, 8'h01, 1'b0, NO_WORD};
    dir_rows[10] = '{OP_PAYLOAD, 8'h7F, 1'b0, NO_WORD};
    dir_rows[11] = '{OP_PAYLOAD, 8'h11, 1'b1, rej(PH_BLOCK)};
    dir_rows[12] = '{OP_END,     8'h00, 1'b1, rej(PH_BLOCK)};
    dir_rows[13] = '{OP_BAD,     8'h55, 1'b1, rej(PH_BLOCK)};
    dir_rows[14] = '{OP_RX,      C_NAK, 1'b0, NO_WORD};
    dir_rows[15] = '{OP_RX,      C_ACK, 1'b1, quiet(PH_FILL)};
    dir_rows[16] = '{OP_PAYLOAD, 8'hFF, 1'b0, NO_WORD};
    dir_rows[17] = '{OP_PAYLOAD, 8'hFF, 1'b0, NO_WORD};
    dir_rows[18] = '{OP_PAYLOAD, 8'hFF, 1'b0, NO_WORD};
    dir_rows[19] = '{OP_PAYLOAD, 8'hFF, 1'b0, NO_WORD};
    dir_rows[20] = '{OP_PAYLOAD, 8'hFF, 1'b0, NO_WORD};
    dir_rows[21] = '{OP_RX,      C_ACK, 1'b1, quiet(PH_FILL)};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      offer(dir_rows[i].op, dir_rows[i].d, dir_rows[i].typed, dir_rows[i].want);

    set_pad(8'hFF);

    // full blocks with random data, walking through the four idling phases
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      gap_mode = gap_mode_t'((blk / 13) % 4);
      if (blk == HOLD_AT) hold_req = 1'b1;
      if (blk == PAD_ZERO_AT) set_pad(8'h00);
      send_payload(DATA_BYTES);
      if ($urandom_range(0, 9) == 0) noise_item(PH_BLOCK);
      while ($urandom_range(0, 99) < 15) offer(OP_RX, C_NAK);
      offer(OP_RX, C_ACK);
    end

    case ($urandom_range(0, 2))
      0:       set_pad(8'h00);
      1:       set_pad(8'hFF);
      default: set_pad(8'($urandom_range(0, 255)));
    endcase

    // one way to close the transfer, since reset comes only once
    fin = fin_kind_t'($urandom_range(0, 2));
    case (fin)
      FIN_PADDED: begin
        send_payload($urandom_range(1, DATA_BYTES - 1));
        offer(OP_END, 8'($urandom_range(0, 255)));
        offer(OP_RX, C_NAK);
        offer(OP_RX, C_ACK);
        repeat (3) noise_item(PH_EOT);
        offer(OP_RX, 8'($urandom_range(0, 255)));
      end
      FIN_EMPTY: begin
        offer(OP_END, 8'($urandom_range(0, 255)));
        repeat (3) noise_item(PH_EOT);
        offer(OP_RX, 8'($urandom_range(0, 255)));
      end
      default: begin
        send_payload(DATA_BYTES);
        do bad = 8'($urandom_range(0, 255)); while (bad == C_ACK || bad == C_NAK);
        offer(OP_RX, bad);
      end
    endcase
    // everything after the end of the transfer is refused
    repeat (8) noise_item(fin == FIN_CANCEL ? PH_ABORT : PH_DONE);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tx_words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && tx_words_due.size() == 0) begin
      $display("xmodem_block_sender_top_test: done, clean");
    end else begin
      $display("xmodem_block_sender_top_test: done, errors");
    end
    $finish;
  end

endmodule

@@ xmodem_block_sender_top.f @@
+incdir+hw/rtl
hw/rtl/xbs_pkg.sv
hw/rtl/xbs_cmd_fifo.sv
hw/rtl/xbs_front.sv
hw/rtl/xbs_back.sv
hw/rtl/xmodem_block_sender_top.sv
dv/xmodem_block_sender_top_test.sv
